// ===== src/sla_pkg.sv =====
// -----------------------------------------------------------------------------
// sla_pkg: shared types and constants of the semi-Lagrangian advection engine
// Controller states, command and status bundles, defaults and field widths.
// -----------------------------------------------------------------------------
package sla_pkg;

   localparam int GRID_DEF  = 64;
   localparam int GHOST_DEF = 1;

   localparam int CFG_AW    = 4;
   localparam int CFG_DW    = 32;
   localparam int REQ_DW    = 64;
   localparam int RSP_DW    = 32;
   localparam int FRAC_W    = 12;

   localparam logic [1:0] REG_COLS    = 2'd0;
   localparam logic [1:0] REG_ROWS    = 2'd1;
   localparam logic [1:0] REG_SCALE_X = 2'd2;
   localparam logic [1:0] REG_SCALE_Y = 2'd3;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_POS,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_LAST,
      ST_BL0,
      ST_BL1,
      ST_DONE
   } sla_state_type;

   typedef struct packed {
      logic       take;
      logic       store;
      logic       vel_read;
      logic       mult;
      logic       trace;
      logic       fld_read;
      logic [1:0] corner;
      logic       row_mac;
      logic       blend0;
      logic       blend1;
      logic       emit;
   } sla_cmd_type;

   typedef struct packed {
      logic is_load;
      logic interior;
      logic out_busy;
   } sla_status_type;

endpackage

// ===== src/sla_csr.sv =====
// -----------------------------------------------------------------------------
// sla_csr: configuration registers
// Grid size and back-trace scale registers behind a simple APB-style port.
// -----------------------------------------------------------------------------
module sla_csr #(
   parameter int GRID = sla_pkg::GRID_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sla_pkg::CFG_AW-1:0]  csr_paddr,
   input  logic [sla_pkg::CFG_DW-1:0]  csr_pwdata,
   output logic [sla_pkg::CFG_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output logic [$clog2(GRID+1)-1:0]   cols,
   output logic [$clog2(GRID+1)-1:0]   rows,
   output logic [15:0]                 scale_x,
   output logic [15:0]                 scale_y
);
   import sla_pkg::*;

   localparam int DIM_W = $clog2(GRID+1);

   logic [DIM_W-1:0] cols_ff, cols_in, rows_ff, rows_in;
   logic [15:0]      sx_ff, sx_in, sy_ff, sy_in;
   logic             wr;
   logic [1:0]       idx;
   logic [DIM_W-1:0] dim_sat;

   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[3:2];

   // clamp the written size to 1..GRID
   always_comb begin
      if (csr_pwdata[6:0] == 7'd0) begin
         dim_sat = DIM_W'(1);
      end else if (int'(csr_pwdata[6:0]) > GRID) begin
         dim_sat = DIM_W'(GRID);
      end else begin
         dim_sat = DIM_W'(csr_pwdata[6:0]);
      end
   end

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      if (wr) begin
         unique case (idx)
            REG_COLS:    cols_in = dim_sat;
            REG_ROWS:    rows_in = dim_sat;
            REG_SCALE_X: sx_in   = csr_pwdata[15:0];
            REG_SCALE_Y: sy_in   = csr_pwdata[15:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= (GRID < 64) ? DIM_W'(GRID) : DIM_W'(64);
         rows_ff <= (GRID < 64) ? DIM_W'(GRID) : DIM_W'(64);
         sx_ff   <= 16'd4096;
         sy_ff   <= 16'd4096;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_COLS:    csr_prdata = CFG_DW'(cols_ff);
         REG_ROWS:    csr_prdata = CFG_DW'(rows_ff);
         REG_SCALE_X: csr_prdata = CFG_DW'(sx_ff);
         REG_SCALE_Y: csr_prdata = CFG_DW'(sy_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cols       = cols_ff;
   assign rows       = rows_ff;
   assign scale_x    = sx_ff;
   assign scale_y    = sy_ff;

endmodule

// ===== src/sla_ctrl.sv =====
// -----------------------------------------------------------------------------
// sla_ctrl: sequencing controller
// Steps one item through decode, then a load's store or the velocity read,
// multiply, trace, four corner reads, final blend and result hand-off.
// -----------------------------------------------------------------------------
module sla_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  sla_pkg::sla_status_type status,
   output sla_pkg::sla_cmd_type    cmd
);
   import sla_pkg::*;

   sla_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (status.is_load) begin
               cmd.store = 1'b1;
               state_in  = ST_IDLE;
            end else if (!status.interior) begin
               state_in = ST_DONE;
            end else begin
               cmd.vel_read = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mult = 1'b1;
            state_in = ST_POS;
         end
         ST_POS: begin
            cmd.trace = 1'b1;
            state_in  = ST_RD0;
         end
         ST_RD0: begin
            cmd.fld_read = 1'b1;
            cmd.corner   = 2'd0;
            state_in     = ST_RD1;
         end
         ST_RD1: begin
            cmd.fld_read = 1'b1;
            cmd.corner   = 2'd1;
            cmd.row_mac  = 1'b1;
            state_in     = ST_RD2;
         end
         ST_RD2: begin
            cmd.fld_read = 1'b1;
            cmd.corner   = 2'd2;
            cmd.row_mac  = 1'b1;
            state_in     = ST_RD3;
         end
         ST_RD3: begin
            cmd.fld_read = 1'b1;
            cmd.corner   = 2'd3;
            cmd.row_mac  = 1'b1;
            state_in     = ST_LAST;
         end
         ST_LAST: begin
            cmd.row_mac = 1'b1;
            state_in    = ST_BL0;
         end
         ST_BL0: begin
            cmd.blend0 = 1'b1;
            state_in   = ST_BL1;
         end
         ST_BL1: begin
            cmd.blend1 = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== src/sla_dp.sv =====
// -----------------------------------------------------------------------------
// sla_dp: advection datapath
// Item register, field and velocity memories, back-trace arithmetic,
// bilinear multiply-accumulate and the result register.
// -----------------------------------------------------------------------------
module sla_dp #(
   parameter int GRID  = sla_pkg::GRID_DEF,
   parameter int GHOST = sla_pkg::GHOST_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sla_pkg::sla_cmd_type        cmd,
   output sla_pkg::sla_status_type     status,
   input  logic                        req_tuser,
   input  logic [sla_pkg::REQ_DW-1:0]  req_tdata,
   input  logic [$clog2(GRID+1)-1:0]   cols,
   input  logic [$clog2(GRID+1)-1:0]   rows,
   input  logic [15:0]                 scale_x,
   input  logic [15:0]                 scale_y,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        rsp_tuser,
   output logic [sla_pkg::RSP_DW-1:0]  rsp_tdata
);
   import sla_pkg::*;

   localparam int PAD     = GRID + 2*GHOST;
   localparam int PW      = $clog2(PAD);
   localparam int DIM_W   = $clog2(GRID+1);
   localparam int FADDR_W = $clog2(PAD*PAD);
   localparam int VADDR_W = $clog2(GRID*GRID);
   localparam int FDEPTH  = PAD*PAD;
   localparam int VDEPTH  = GRID*GRID;
   localparam int SW      = 11;

   // item register
   logic               op_ff;
   logic signed [7:0]  cx_ff, cy_ff;
   logic [15:0]        fv_ff, vxi_ff, vyi_ff;

   logic signed [SW-1:0] cxs, cys, cols_s, rows_s, gh_s;
   logic                 interior, in_pad;

   logic [15:0] fmem [FDEPTH];
   logic [31:0] vmem [VDEPTH];
   logic [15:0] frd_ff;
   logic [31:0] vrd_ff;
   logic [FADDR_W-1:0] faddr;
   logic [VADDR_W-1:0] vaddr;
   logic [PW-1:0]      lx, ly;

   logic signed [32:0] prod_ff [2];
   logic [PW-1:0]      k1_ff [2], k2_ff [2];
   logic [FRAC_W-1:0]  w2_ff [2];
   logic [1:0]         rdc_ff;

   logic signed [29:0] rowt_ff, fy_ff [2];
   logic signed [43:0] acc_ff;

   logic               out_v_ff, out_bad_ff;
   logic [15:0]        out_val_ff;
   logic signed [7:0]  out_x_ff, out_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= req_tuser;
         cx_ff  <= req_tdata[7:0];
         cy_ff  <= req_tdata[15:8];
         fv_ff  <= req_tdata[31:16];
         vxi_ff <= req_tdata[47:32];
         vyi_ff <= req_tdata[63:48];
      end
   end

   assign cxs    = SW'(cx_ff);
   assign cys    = SW'(cy_ff);
   assign cols_s = signed'(SW'(cols));
   assign rows_s = signed'(SW'(rows));
   assign gh_s   = signed'(SW'(GHOST));

   assign interior = (cxs >= 0) && (cxs < cols_s) && (cys >= 0) && (cys < rows_s);
   assign in_pad   = (cxs >= -gh_s) && (cxs < cols_s + gh_s) &&
                     (cys >= -gh_s) && (cys < rows_s + gh_s);

   assign status.is_load  = (op_ff == OP_LOAD);
   assign status.interior = interior;
   assign status.out_busy = out_v_ff && !rsp_tready;

   // padded load coordinates
   logic signed [SW-1:0] lxs, lys;
   assign lxs = cxs + gh_s;
   assign lys = cys + gh_s;
   assign lx  = lxs[PW-1:0];
   assign ly  = lys[PW-1:0];

   always_comb begin
      if (cmd.store) begin
         faddr = FADDR_W'(lx) + FADDR_W'(ly) * FADDR_W'(PAD);
      end else begin
         faddr = FADDR_W'(k1_ff[0]) + FADDR_W'(k1_ff[1]) * FADDR_W'(PAD);
         if (cmd.corner[0]) faddr = FADDR_W'(k2_ff[0]) + FADDR_W'(k1_ff[1]) * FADDR_W'(PAD);
         if (cmd.corner[1]) faddr = FADDR_W'(cmd.corner[0] ? k2_ff[0] : k1_ff[0]) +
                                    FADDR_W'(k2_ff[1]) * FADDR_W'(PAD);
      end
   end

   assign vaddr = VADDR_W'(cx_ff) + VADDR_W'(cy_ff) * VADDR_W'(GRID);

   always_ff @(posedge clock) begin
      if (cmd.store && in_pad) begin
         fmem[faddr] <= fv_ff;
      end
      if (cmd.fld_read) begin
         frd_ff <= fmem[faddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && interior) begin
         vmem[vaddr] <= {vyi_ff, vxi_ff};
      end
      if (cmd.vel_read) begin
         vrd_ff <= vmem[vaddr];
      end
   end

   // scale times velocity, one multiplier per axis
   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ff[0] <= signed'({1'b0, scale_x}) * signed'(vrd_ff[15:0]);
         prod_ff[1] <= signed'({1'b0, scale_y}) * signed'(vrd_ff[31:16]);
      end
   end

   // back-trace, clamp to padded grid, split into corner index and weight
   logic signed [35:0] p20 [2];
   logic signed [28:0] pp [2], ph [2];
   logic [PW-1:0]      hk [2], k1 [2];

   always_comb begin
      hk[0] = PW'(cols - DIM_W'(1)) + PW'(2*GHOST);
      hk[1] = PW'(rows - DIM_W'(1)) + PW'(2*GHOST);
      for (int a = 0; a < 2; a++) begin
         p20[a] = (a == 0) ? signed'({cx_ff, 20'b0}) : signed'({cy_ff, 20'b0});
         p20[a] = p20[a] - 36'(prod_ff[a]);
         pp[a]  = 29'(signed'(p20[a][35:8])) + 29'(GHOST << FRAC_W);
         ph[a]  = signed'({1'b0, 28'(hk[a]) << FRAC_W});
         if (pp[a] < 0) pp[a] = '0;
         else if (pp[a] > ph[a]) pp[a] = ph[a];
         k1[a] = pp[a][FRAC_W +: PW];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trace) begin
         for (int a = 0; a < 2; a++) begin
            k1_ff[a] <= k1[a];
            k2_ff[a] <= (k1[a] == hk[a]) ? k1[a] : k1[a] + PW'(1);
            w2_ff[a] <= pp[a][FRAC_W-1:0];
         end
      end
   end

   // row blends: even corner starts a row, odd corner finishes it
   logic [FRAC_W:0]    wsel;
   logic signed [29:0] cprod;

   assign wsel  = rdc_ff[0] ? {1'b0, w2_ff[0]} : (13'd4096 - {1'b0, w2_ff[0]});
   assign cprod = signed'({1'b0, wsel}) * signed'(frd_ff);

   always_ff @(posedge clock) begin
      if (cmd.fld_read) begin
         rdc_ff <= cmd.corner;
      end
      if (cmd.row_mac) begin
         if (!rdc_ff[0]) begin
            rowt_ff <= cprod;
         end else begin
            fy_ff[rdc_ff[1]] <= rowt_ff + cprod;
         end
      end
   end

   // column blend: blend0 starts the sum, blend1 adds the second row
   logic [FRAC_W:0]    wy;
   logic signed [43:0] bprod;

   assign wy    = cmd.blend1 ? {1'b0, w2_ff[1]} : (13'd4096 - {1'b0, w2_ff[1]});
   assign bprod = signed'({1'b0, wy}) * (cmd.blend1 ? fy_ff[1] : fy_ff[0]);

   always_ff @(posedge clock) begin
      if (cmd.blend0) begin
         acc_ff <= bprod;
      end else if (cmd.blend1) begin
         acc_ff <= acc_ff + bprod;
      end
   end

   // round half up to Q8.8 and saturate
   logic signed [43:0] rsum, rsh;
   logic [15:0]        rsat;

   always_comb begin
      rsum = acc_ff + 44'sd8388608;
      rsh  = rsum >>> 24;
      if (rsh > 44'sd32767) rsat = 16'h7FFF;
      else if (rsh < -44'sd32768) rsat = 16'h8000;
      else rsat = rsh[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_x_ff   <= cx_ff;
         out_y_ff   <= cy_ff;
         out_bad_ff <= !interior;
         out_val_ff <= interior ? rsat : 16'd0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_bad_ff;
   assign rsp_tdata  = {out_val_ff, out_y_ff, out_x_ff};

endmodule

// ===== src/semi_lagrangian_advection_top.sv =====
// -----------------------------------------------------------------------------
// semi_lagrangian_advection_top: semi-Lagrangian advection engine
// Loads a field and velocity grid, then computes bilinear back-traced values.
// -----------------------------------------------------------------------------
// One item is in work at a time. A load item is accepted, then written to
// memory, and gives no result. A compute item for an interior cell passes
// from accept to result through a velocity read, the scale multiply, the
// back-trace, four corner reads through the single port of the field memory,
// and a two-step blend; a cell outside the interior returns bad_cell straight
// after decode. A result waits in the output register while the next item is
// accepted. Memories have no reset; a cell read before it was loaded returns
// undefined data.
module semi_lagrangian_advection_top #(
   parameter int GRID  = sla_pkg::GRID_DEF,
   parameter int GHOST = sla_pkg::GHOST_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_tuser,   // opcode
   input  logic [sla_pkg::REQ_DW-1:0]  req_tdata,   // cell_x, cell_y, field_value, vel_x, vel_y
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        rsp_tuser,   // bad_cell
   output logic [sla_pkg::RSP_DW-1:0]  rsp_tdata,   // res_x, res_y, advected
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sla_pkg::CFG_AW-1:0]  csr_paddr,
   input  logic [sla_pkg::CFG_DW-1:0]  csr_pwdata,
   output logic [sla_pkg::CFG_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import sla_pkg::*;

   localparam int DIM_W = $clog2(GRID+1);

   sla_cmd_type    cmd;
   sla_status_type status;
   logic [DIM_W-1:0] cols, rows;
   logic [15:0]      scale_x, scale_y;

   sla_csr #(.GRID(GRID)) u_csr (
      .clock, .reset,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready,
      .cols, .rows, .scale_x, .scale_y
   );

   sla_ctrl u_ctrl (
      .clock, .reset,
      .req_tvalid, .req_tready,
      .status, .cmd
   );

   sla_dp #(.GRID(GRID), .GHOST(GHOST)) u_dp (
      .clock, .reset,
      .cmd, .status,
      .req_tuser, .req_tdata,
      .cols, .rows, .scale_x, .scale_y,
      .rsp_tvalid, .rsp_tready, .rsp_tuser, .rsp_tdata
   );

endmodule

// ===== src/sla_checker.sv =====
// -----------------------------------------------------------------------------
// sla_checker: port-level checks for the advection engine
// Watches the stream ports and flags ordering and result-encoding slips.
// -----------------------------------------------------------------------------
module sla_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tuser,
   input logic [31:0] rsp_tdata
);

   // one item in work: no second accept right after the first
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted two items back to back");

   // no result can appear in the cycle after an accept
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result appeared one cycle after accept");

   // a bad cell carries a zero value
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[31:16] == 16'd0))
      else $error("bad cell result with nonzero value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result dropped or changed");

endmodule

bind semi_lagrangian_advection_top sla_checker u_sla_checker (
   .clock, .reset, .req_tvalid, .req_tready,
   .rsp_tvalid, .rsp_tready, .rsp_tuser, .rsp_tdata
);
